// ----- design/spd_pkg.sv -----
// Shared widths, command codes and sequencer states of the shortest-path block.
package spd_pkg;

  localparam int VTX_W       = 4;
  localparam int DIST_W      = 20;
  localparam int CFG_W       = 5;
  localparam int WIN_W       = 16;
  localparam int MAX_RESULTS = 16;
  localparam int RES_W       = $clog2(MAX_RESULTS);

  localparam logic [DIST_W-1:0] DIST_MAX     = 20'hFFFFF;
  localparam logic [CFG_W-1:0]  VCOUNT_RESET = 5'd16;

  localparam logic CMD_EDGE  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEL,
    ST_SEL_DONE,
    ST_RELAX,
    ST_PATH_RD,
    ST_PATH_WR,
    ST_FAIL,
    ST_DONE_HOLD
  } spd_state_t;

endpackage

// ----- design/spd_ifs.sv -----
// Request and result channel interfaces of the shortest-path block.
interface spd_in_if;
  import spd_pkg::*;

  logic             valid;
  logic             ready;
  logic             cmd;
  logic [VTX_W-1:0] from_vertex;
  logic [VTX_W-1:0] to_vertex;
  logic [WIN_W-1:0] weight;
  logic             edge_present;

  modport source (output valid, cmd, from_vertex, to_vertex, weight, edge_present,
                  input ready);
  modport sink   (input valid, cmd, from_vertex, to_vertex, weight, edge_present,
                  output ready);
endinterface

interface spd_out_if;
  import spd_pkg::*;

  logic              valid;
  logic              ready;
  logic [VTX_W-1:0]  path_vertex;
  logic [DIST_W-1:0] path_distance;
  logic              reachable;
  logic              last;

  modport source (output valid, path_vertex, path_distance, reachable, last,
                  input ready);
  modport sink   (input valid, path_vertex, path_distance, reachable, last,
                  output ready);
endinterface

// ----- design/spd_edge_mem.sv -----
// Adjacency matrix store: one write port, one registered read port.
module spd_edge_mem #(
  parameter int MAX_VERTICES = 16,
  parameter int WEIGHT_BITS  = 16
) (
  input  logic                                    clk,
  input  logic                                    wr_en,
  input  logic [2*$clog2(MAX_VERTICES)-1:0]       wr_addr,
  input  logic [WEIGHT_BITS:0]                    wr_data,
  input  logic [2*$clog2(MAX_VERTICES)-1:0]       rd_addr,
  output logic [WEIGHT_BITS:0]                    rd_data
);
  localparam int EA_W  = 2 * $clog2(MAX_VERTICES);
  localparam int DEPTH = 1 << EA_W;

  logic [WEIGHT_BITS:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- design/spd_alu.sv -----
// Shared saturating adder and less-than comparator used by every scan step.
module spd_alu #(
  parameter int WEIGHT_BITS = 16
) (
  input  logic [spd_pkg::DIST_W-1:0] base,
  input  logic [WEIGHT_BITS-1:0]     addend,
  input  logic [spd_pkg::DIST_W-1:0] limit,
  output logic [spd_pkg::DIST_W-1:0] sum,
  output logic                       lt
);
  import spd_pkg::*;

  localparam int SW = ((DIST_W > WEIGHT_BITS) ? DIST_W : WEIGHT_BITS) + 1;

  logic [SW-1:0] full;

  always_comb begin
    full = SW'(base) + SW'(addend);
    // clamp path sums at the top of the distance range
    if (full > SW'(DIST_MAX)) begin
      sum = DIST_MAX;
    end else begin
      sum = DIST_W'(full);
    end
    lt = (sum < limit);
  end

endmodule

// ----- design/spd_ctrl.sv -----
// Sequencer: edge writes, vertex selection and relaxation scans, path walk.
module spd_ctrl #(
  parameter int MAX_VERTICES = 16,
  parameter int WEIGHT_BITS  = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [spd_pkg::CFG_W-1:0]           cfg_vertex_count,
  spd_in_if.sink                              in_ch,
  spd_out_if.source                           out_ch,
  output logic                                edge_we,
  output logic [2*$clog2(MAX_VERTICES)-1:0]   edge_waddr,
  output logic [WEIGHT_BITS:0]                edge_wdata,
  output logic [2*$clog2(MAX_VERTICES)-1:0]   edge_raddr,
  input  logic [WEIGHT_BITS:0]                edge_rdata,
  output logic [spd_pkg::DIST_W-1:0]          alu_base,
  output logic [WEIGHT_BITS-1:0]              alu_addend,
  output logic [spd_pkg::DIST_W-1:0]          alu_limit,
  input  logic [spd_pkg::DIST_W-1:0]          alu_sum,
  input  logic                                alu_lt
);
  import spd_pkg::*;

  localparam int VIDX_W = $clog2(MAX_VERTICES);
  localparam int CNT_W  = $clog2(MAX_VERTICES + 1);
  localparam int CW     = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam int NODE_W = DIST_W + VIDX_W;
  localparam int NDEPTH = 1 << VIDX_W;

  spd_state_t state_r, state_nxt;

  logic [CNT_W-1:0]        n_r, n_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [VIDX_W-1:0]       src_r, src_nxt;
  logic [VIDX_W-1:0]       dst_r, dst_nxt;
  logic [VTX_W-1:0]        dst_raw_r, dst_raw_nxt;
  logic [VIDX_W-1:0]       cur_r, cur_nxt;
  logic [DIST_W-1:0]       best_r, best_nxt;
  logic                    found_r, found_nxt;
  logic [MAX_VERTICES-1:0] settled_r, settled_nxt;
  logic [MAX_VERTICES-1:0] reached_r, reached_nxt;
  logic [RES_W-1:0]        k_r, k_nxt;
  logic [VIDX_W-1:0]       p_r, p_nxt;

  logic                    ov_r, ov_nxt;
  logic [VTX_W-1:0]        ovtx_r, ovtx_nxt;
  logic [DIST_W-1:0]       odist_r, odist_nxt;
  logic                    oreach_r, oreach_nxt;
  logic                    olast_r, olast_nxt;

  // distance and predecessor per vertex, packed {pred, dist}
  logic [NODE_W-1:0] node_mem [NDEPTH];
  logic [NODE_W-1:0] node_rd_r;
  logic              node_we;
  logic [VIDX_W-1:0] node_waddr;
  logic [NODE_W-1:0] node_wdata;
  logic [VIDX_W-1:0] node_raddr;

  logic [CW-1:0]     cfg_ext;
  logic [CNT_W-1:0]  n_eff;
  logic              in_acc;
  logic              query_bad;
  logic              edge_in_range;
  logic              proc_on;
  logic [VIDX_W-1:0] proc_idx;
  logic              scan_end;
  logic [DIST_W-1:0] dist_rd;
  logic [VIDX_W-1:0] pred_rd;
  logic              e_present;
  logic [WEIGHT_BITS-1:0] e_weight;
  logic              sel_take;
  logic              relax_upd;
  logic              slot_free;
  logic              path_end;

  // clamp the configured count into 1..MAX_VERTICES
  always_comb begin
    cfg_ext = CW'(cfg_vertex_count);
    if (cfg_ext == '0) begin
      n_eff = CNT_W'(1);
    end else if (cfg_ext > CW'(MAX_VERTICES)) begin
      n_eff = CNT_W'(MAX_VERTICES);
    end else begin
      n_eff = CNT_W'(cfg_ext);
    end
  end

  assign in_acc        = in_ch.valid && in_ch.ready;
  assign query_bad     = (CW'(in_ch.from_vertex) >= CW'(n_eff)) ||
                         (CW'(in_ch.to_vertex) >= CW'(n_eff));
  assign edge_in_range = (CW'(in_ch.from_vertex) < CW'(MAX_VERTICES)) &&
                         (CW'(in_ch.to_vertex) < CW'(MAX_VERTICES));
  assign proc_on       = (cnt_r != '0);
  assign proc_idx      = VIDX_W'(cnt_r - CNT_W'(1));
  assign scan_end      = (cnt_r == n_r);
  assign dist_rd       = node_rd_r[DIST_W-1:0];
  assign pred_rd       = node_rd_r[DIST_W +: VIDX_W];
  assign e_present     = edge_rdata[WEIGHT_BITS];
  assign e_weight      = edge_rdata[WEIGHT_BITS-1:0];
  assign sel_take      = proc_on && !settled_r[proc_idx] && reached_r[proc_idx] &&
                         (!found_r || alu_lt);
  assign relax_upd     = proc_on && !settled_r[proc_idx] && e_present &&
                         (!reached_r[proc_idx] || alu_lt);
  assign slot_free     = !ov_r || out_ch.ready;
  assign path_end      = (p_r == src_r) || (k_r == RES_W'(MAX_RESULTS - 1));

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_ch.cmd == CMD_QUERY)) begin
          state_nxt = query_bad ? ST_FAIL : ST_SEL;
        end
      end
      ST_SEL: begin
        if (scan_end) begin
          state_nxt = ST_SEL_DONE;
        end
      end
      ST_SEL_DONE: begin
        priority if (!found_r) begin
          state_nxt = ST_FAIL;
        end else if (cur_r == dst_r) begin
          state_nxt = ST_PATH_RD;
        end else begin
          state_nxt = ST_RELAX;
        end
      end
      ST_RELAX: begin
        if (scan_end) begin
          state_nxt = ST_SEL;
        end
      end
      ST_PATH_RD: begin
        state_nxt = ST_PATH_WR;
      end
      ST_PATH_WR: begin
        if (slot_free) begin
          state_nxt = path_end ? ST_IDLE : ST_PATH_RD;
        end
      end
      ST_FAIL: begin
        if (slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_DONE_HOLD: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // datapath and memory controls
  always_comb begin
    n_nxt       = n_r;
    cnt_nxt     = cnt_r;
    src_nxt     = src_r;
    dst_nxt     = dst_r;
    dst_raw_nxt = dst_raw_r;
    cur_nxt     = cur_r;
    best_nxt    = best_r;
    found_nxt   = found_r;
    settled_nxt = settled_r;
    reached_nxt = reached_r;
    k_nxt       = k_r;
    p_nxt       = p_r;
    ov_nxt      = ov_r;
    ovtx_nxt    = ovtx_r;
    odist_nxt   = odist_r;
    oreach_nxt  = oreach_r;
    olast_nxt   = olast_r;

    node_we    = 1'b0;
    node_waddr = proc_idx;
    node_wdata = {cur_r, alu_sum};
    node_raddr = VIDX_W'(cnt_r);

    edge_we    = 1'b0;
    edge_waddr = {VIDX_W'(in_ch.from_vertex), VIDX_W'(in_ch.to_vertex)};
    edge_wdata = in_ch.edge_present ? {1'b1, WEIGHT_BITS'(in_ch.weight)} : '0;
    edge_raddr = {cur_r, VIDX_W'(cnt_r)};

    // shared unit: compare in selection, add and compare in relaxation
    if (state_r == ST_RELAX) begin
      alu_base   = best_r;
      alu_addend = e_weight;
      alu_limit  = dist_rd;
    end else begin
      alu_base   = dist_rd;
      alu_addend = '0;
      alu_limit  = best_r;
    end

    if (ov_r && out_ch.ready) begin
      ov_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_ch.cmd == CMD_EDGE) begin
            edge_we = edge_in_range;
          end else begin
            n_nxt       = n_eff;
            src_nxt     = VIDX_W'(in_ch.from_vertex);
            dst_nxt     = VIDX_W'(in_ch.to_vertex);
            dst_raw_nxt = in_ch.to_vertex;
            cnt_nxt     = '0;
            found_nxt   = 1'b0;
            settled_nxt = '0;
            reached_nxt = '0;
            if (!query_bad) begin
              reached_nxt[VIDX_W'(in_ch.from_vertex)] = 1'b1;
              node_we    = 1'b1;
              node_waddr = VIDX_W'(in_ch.from_vertex);
              node_wdata = {VIDX_W'(in_ch.from_vertex), {DIST_W{1'b0}}};
            end
          end
        end
      end
      ST_SEL: begin
        if (sel_take) begin
          best_nxt  = dist_rd;
          cur_nxt   = proc_idx;
          found_nxt = 1'b1;
        end
        if (!scan_end) begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      ST_SEL_DONE: begin
        if (found_r) begin
          settled_nxt[cur_r] = 1'b1;
        end
        cnt_nxt = '0;
        p_nxt   = dst_r;
        k_nxt   = '0;
      end
      ST_RELAX: begin
        if (relax_upd) begin
          node_we               = 1'b1;
          reached_nxt[proc_idx] = 1'b1;
        end
        if (scan_end) begin
          cnt_nxt   = '0;
          found_nxt = 1'b0;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      ST_PATH_RD: begin
        node_raddr = p_r;
      end
      ST_PATH_WR: begin
        node_raddr = p_r;
        if (slot_free) begin
          ov_nxt     = 1'b1;
          ovtx_nxt   = VTX_W'(p_r);
          odist_nxt  = dist_rd;
          oreach_nxt = 1'b1;
          olast_nxt  = path_end;
          if (!path_end) begin
            p_nxt = pred_rd;
            k_nxt = k_r + RES_W'(1);
          end
        end
      end
      ST_FAIL: begin
        if (slot_free) begin
          ov_nxt     = 1'b1;
          ovtx_nxt   = dst_raw_r;
          odist_nxt  = '0;
          oreach_nxt = 1'b0;
          olast_nxt  = 1'b1;
        end
      end
      ST_DONE_HOLD: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      ov_r      <= 1'b0;
      settled_r <= '0;
      reached_r <= '0;
      found_r   <= 1'b0;
      cnt_r     <= '0;
    end else begin
      state_r   <= state_nxt;
      ov_r      <= ov_nxt;
      settled_r <= settled_nxt;
      reached_r <= reached_nxt;
      found_r   <= found_nxt;
      cnt_r     <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r       <= n_nxt;
    src_r     <= src_nxt;
    dst_r     <= dst_nxt;
    dst_raw_r <= dst_raw_nxt;
    cur_r     <= cur_nxt;
    best_r    <= best_nxt;
    k_r       <= k_nxt;
    p_r       <= p_nxt;
    ovtx_r    <= ovtx_nxt;
    odist_r   <= odist_nxt;
    oreach_r  <= oreach_nxt;
    olast_r   <= olast_nxt;
  end

  always_ff @(posedge clk) begin
    if (node_we) begin
      node_mem[node_waddr] <= node_wdata;
    end
    node_rd_r <= node_mem[node_raddr];
  end

  assign in_ch.ready          = (state_r == ST_IDLE);
  assign out_ch.valid         = ov_r;
  assign out_ch.path_vertex   = ovtx_r;
  assign out_ch.path_distance = odist_r;
  assign out_ch.reachable     = oreach_r;
  assign out_ch.last          = olast_r;

endmodule

// ----- design/shortest_path_dijkstra.sv -----
// Shortest-path block top level: configuration register, matrix store, sequencer.
//
// Usage: requests arrive on in_ch (valid/ready). cmd 0 writes one matrix edge
// (row from_vertex, column to_vertex, weight, edge_present) and gives no
// result. cmd 1 runs a query from from_vertex to to_vertex over the first
// vertex_count vertices and gives one result per path vertex on out_ch,
// target first, source last, the final one flagged by last. An unreachable
// target or an out-of-range source or target gives a single result with
// reachable low. cfg_we/cfg_wdata set vertex_count; the user must write it
// only while idle, the block itself does not enforce this. A query runs up
// to n selection rounds, each a selection scan and a relaxation scan over
// the one memory port plus a decision state, then a read and a write state
// per path vertex. The block takes no request during a query. Results sit
// in an output register: a stalled receiver holds the walk, and the next
// request is taken once the last result is loaded. Reset clears the control
// state and sets vertex_count to 16; the matrix contents are kept undefined
// until written.
module shortest_path_dijkstra #(
  parameter int MAX_VERTICES = 16,
  parameter int WEIGHT_BITS  = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [spd_pkg::CFG_W-1:0] cfg_wdata,
  spd_in_if.sink                    in_ch,
  spd_out_if.source                 out_ch
);
  import spd_pkg::*;

  localparam int EA_W = 2 * $clog2(MAX_VERTICES);

  logic [CFG_W-1:0]       vertex_count_r;
  logic                   edge_we;
  logic [EA_W-1:0]        edge_waddr;
  logic [WEIGHT_BITS:0]   edge_wdata;
  logic [EA_W-1:0]        edge_raddr;
  logic [WEIGHT_BITS:0]   edge_rdata;
  logic [DIST_W-1:0]      alu_base;
  logic [WEIGHT_BITS-1:0] alu_addend;
  logic [DIST_W-1:0]      alu_limit;
  logic [DIST_W-1:0]      alu_sum;
  logic                   alu_lt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vertex_count_r <= VCOUNT_RESET;
    end else if (cfg_we) begin
      vertex_count_r <= cfg_wdata;
    end
  end

  spd_edge_mem #(
    .MAX_VERTICES (MAX_VERTICES),
    .WEIGHT_BITS  (WEIGHT_BITS)
  ) u_edge_mem (
    .clk     (clk),
    .wr_en   (edge_we),
    .wr_addr (edge_waddr),
    .wr_data (edge_wdata),
    .rd_addr (edge_raddr),
    .rd_data (edge_rdata)
  );

  spd_alu #(
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_alu (
    .base   (alu_base),
    .addend (alu_addend),
    .limit  (alu_limit),
    .sum    (alu_sum),
    .lt     (alu_lt)
  );

  spd_ctrl #(
    .MAX_VERTICES (MAX_VERTICES),
    .WEIGHT_BITS  (WEIGHT_BITS)
  ) u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_vertex_count (vertex_count_r),
    .in_ch            (in_ch),
    .out_ch           (out_ch),
    .edge_we          (edge_we),
    .edge_waddr       (edge_waddr),
    .edge_wdata       (edge_wdata),
    .edge_raddr       (edge_raddr),
    .edge_rdata       (edge_rdata),
    .alu_base         (alu_base),
    .alu_addend       (alu_addend),
    .alu_limit        (alu_limit),
    .alu_sum          (alu_sum),
    .alu_lt           (alu_lt)
  );

  // a query keeps the block busy in the cycle after it is taken
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && (in_ch.cmd == CMD_QUERY)) |=> !in_ch.ready)
    else $error("request taken straight after a query");

  // after an edge write the block takes a request again in the next cycle
  a_edge_single: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && (in_ch.cmd == CMD_EDGE)) |=> in_ch.ready)
    else $error("edge write held the request channel");

  // no new request while a path is only partly delivered
  a_mid_path_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.last) |-> !in_ch.ready)
    else $error("request channel open in the middle of a path");

endmodule
